// ===== hdl/pvts_pkg.sv =====
// ----------------------------------------------------------------------------
// pvts_pkg: shared types and constants for the tetrahedral cell volume block
// Command codes, sequencer states and the fixed widths of the six-fold sum,
// the volume result and the radix-16 divide-by-six step.
// ----------------------------------------------------------------------------
package pvts_pkg;

   // Command codes carried on the input channel
   typedef enum logic [2:0] {
      CMD_CELL_CENTRE = 3'd0,
      CMD_FACE_CENTRE = 3'd1,
      CMD_FACE_NODE   = 3'd2,
      CMD_FACE_END    = 3'd3,
      CMD_CELL_END    = 3'd4
   } cmd_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DRAIN,
      ST_ABS,
      ST_ADD,
      ST_DIV,
      ST_DONE
   } state_type;

   localparam int CMD_W  = 3;
   localparam int SUM_W  = 64;
   localparam int VOL_W  = 63;

   // Multiply schedule: six cross-product terms, then three dot-product terms
   localparam int          STEP_W    = 4;
   localparam logic [3:0]  STEP_LAST = 4'd8;

   // Divide by six, four quotient bits per cycle
   localparam int          DIV_DIGIT_BITS = 4;
   localparam int          DIV_CNT_W      = 4;
   localparam logic [3:0]  DIV_LAST       = 4'd15;
   localparam int          REM_W          = 3;
   localparam logic [3:0]  DIV_BASE       = 4'd6;

endpackage

// ===== hdl/polyhedron_volume_tet_sum_top.sv =====
// ----------------------------------------------------------------------------
// polyhedron_volume_tet_sum_top: cell volume by tetrahedral decomposition
// Accumulates |(fc-cc) . ((p-cc) x (q-cc))| for every face edge of a cell on
// one shared signed multiplier and emits floor(sum / 6) at cell end.
//
//   channel | ports        | direction | carries
//   --------+--------------+-----------+-----------------------------------
//   req     | req_valid/   | in        | command, coord_x, coord_y, coord_z
//           | req_ready    |           |
//   rsp     | rsp_valid/   | out       | cell_volume, saturated
//           | rsp_ready    |           |
//
// Cell centre, face centre, first face node, face end without nodes and
// ignored codes are taken in the idle state. A node or face end that closes
// an edge runs accept, 9 multiplier issues, drain, absolute value and
// saturating add. Cell end runs 16 radix-16 divide steps, then waits for the
// output register to empty. Reset is synchronous, with no clearing pass.
// A held result stops the input only once a later cell end finishes dividing.
// ----------------------------------------------------------------------------
module polyhedron_volume_tet_sum_top #(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pvts_pkg::CMD_W-1:0]    req_command,
   input  logic signed [COORD_BITS-1:0]  req_coord_x,
   input  logic signed [COORD_BITS-1:0]  req_coord_y,
   input  logic signed [COORD_BITS-1:0]  req_coord_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pvts_pkg::VOL_W-1:0]    rsp_cell_volume,
   output logic                          rsp_saturated
);

   localparam int DW   = COORD_BITS + 1;   // coordinate difference
   localparam int CW   = 2 * DW;           // cross-product component
   localparam int PW   = DW + CW;          // multiplier product
   localparam int DETW = PW + 1;           // triple product

   // State and control
   pvts_pkg::state_type state_ff, state_in;
   logic [pvts_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [pvts_pkg::STEP_W-1:0]    pstep_ff;
   logic                           pvld_ff;
   logic [pvts_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                           has_node_ff;
   logic [pvts_pkg::SUM_W-1:0]     sum_ff;
   logic                           ovf_ff;
   logic                           rsp_valid_ff, rsp_valid_in;

   // Stored points
   logic signed [COORD_BITS-1:0] cc_ff    [3];
   logic signed [COORD_BITS-1:0] fc_ff    [3];
   logic signed [COORD_BITS-1:0] first_ff [3];
   logic signed [COORD_BITS-1:0] prev_ff  [3];
   logic signed [COORD_BITS-1:0] req_pt   [3];

   // Datapath
   logic signed [DW-1:0]   a_ff [3];
   logic signed [DW-1:0]   b_ff [3];
   logic signed [DW-1:0]   d_ff [3];
   logic signed [CW-1:0]   cross_ff [3];
   logic signed [PW-1:0]   prod_ff;
   logic signed [DETW-1:0] det_ff;
   logic [pvts_pkg::SUM_W-1:0] mag_ff;
   logic [pvts_pkg::SUM_W-1:0] div_ff, div_in;
   logic [pvts_pkg::REM_W-1:0] rem_ff, rem_in;
   logic                       sat_hold_ff;
   logic [pvts_pkg::VOL_W-1:0] rsp_vol_ff;
   logic                       rsp_sat_ff;

   logic signed [DW-1:0] req_d   [3];
   logic signed [DW-1:0] fc_d    [3];
   logic signed [DW-1:0] prev_d  [3];
   logic signed [DW-1:0] first_d [3];

   logic signed [DW-1:0]   mul_a;
   logic signed [CW-1:0]   mul_b;
   logic signed [PW-1:0]   mul_p;
   logic signed [DETW-1:0] det_abs;
   logic [pvts_pkg::SUM_W:0] sum_wide;
   logic [pvts_pkg::DIV_DIGIT_BITS-1:0] div_trial;

   logic accept;
   logic start_edge;
   logic start_div;
   logic rsp_load;
   logic is_node;

   assign req_pt[0] = req_coord_x;
   assign req_pt[1] = req_coord_y;
   assign req_pt[2] = req_coord_z;

   // Differences against the cell centre
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         req_d[i]   = {req_pt[i][COORD_BITS-1], req_pt[i]} -
                      {cc_ff[i][COORD_BITS-1], cc_ff[i]};
         fc_d[i]    = {fc_ff[i][COORD_BITS-1], fc_ff[i]} -
                      {cc_ff[i][COORD_BITS-1], cc_ff[i]};
         prev_d[i]  = {prev_ff[i][COORD_BITS-1], prev_ff[i]} -
                      {cc_ff[i][COORD_BITS-1], cc_ff[i]};
         first_d[i] = {first_ff[i][COORD_BITS-1], first_ff[i]} -
                      {cc_ff[i][COORD_BITS-1], cc_ff[i]};
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pvts_pkg::ST_IDLE: begin
            if (start_edge) begin
               state_in = pvts_pkg::ST_MUL;
            end else if (start_div) begin
               state_in = pvts_pkg::ST_DIV;
            end
         end
         pvts_pkg::ST_MUL: begin
            if (step_ff == pvts_pkg::STEP_LAST) begin
               state_in = pvts_pkg::ST_DRAIN;
            end
         end
         pvts_pkg::ST_DRAIN: state_in = pvts_pkg::ST_ABS;
         pvts_pkg::ST_ABS:   state_in = pvts_pkg::ST_ADD;
         pvts_pkg::ST_ADD:   state_in = pvts_pkg::ST_IDLE;
         pvts_pkg::ST_DIV: begin
            if (div_cnt_ff == pvts_pkg::DIV_LAST) begin
               state_in = pvts_pkg::ST_DONE;
            end
         end
         pvts_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = pvts_pkg::ST_IDLE;
            end
         end
         default: state_in = pvts_pkg::ST_IDLE;
      endcase
   end

   // Control outputs of the sequencer
   always_comb begin
      req_ready  = (state_ff == pvts_pkg::ST_IDLE);
      accept     = req_valid && req_ready;
      is_node    = (req_command == pvts_pkg::CMD_FACE_NODE);
      start_edge = accept && has_node_ff &&
                   (is_node || (req_command == pvts_pkg::CMD_FACE_END));
      start_div  = accept && (req_command == pvts_pkg::CMD_CELL_END);
      rsp_load   = (state_ff == pvts_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);
      step_in    = (state_ff == pvts_pkg::ST_MUL) ? step_ff + 1'b1 : '0;
      div_cnt_in = (state_ff == pvts_pkg::ST_DIV) ? div_cnt_ff + 1'b1 : '0;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   // Select multiplier operands for the current step
   always_comb begin
      case (step_ff)
         4'd0: begin mul_a = b_ff[1]; mul_b = CW'(d_ff[2]); end
         4'd1: begin mul_a = b_ff[2]; mul_b = CW'(d_ff[1]); end
         4'd2: begin mul_a = b_ff[2]; mul_b = CW'(d_ff[0]); end
         4'd3: begin mul_a = b_ff[0]; mul_b = CW'(d_ff[2]); end
         4'd4: begin mul_a = b_ff[0]; mul_b = CW'(d_ff[1]); end
         4'd5: begin mul_a = b_ff[1]; mul_b = CW'(d_ff[0]); end
         4'd6: begin mul_a = a_ff[0]; mul_b = cross_ff[0]; end
         4'd7: begin mul_a = a_ff[1]; mul_b = cross_ff[1]; end
         4'd8: begin mul_a = a_ff[2]; mul_b = cross_ff[2]; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      mul_p = mul_a * mul_b;
   end

   // Magnitude and saturating add
   always_comb begin
      det_abs  = det_ff[DETW-1] ? -det_ff : det_ff;
      sum_wide = {1'b0, sum_ff} + {1'b0, mag_ff};
   end

   // Four restoring divide-by-six steps per cycle
   always_comb begin
      rem_in    = rem_ff;
      div_in    = div_ff;
      div_trial = '0;
      for (int i = 0; i < pvts_pkg::DIV_DIGIT_BITS; i++) begin
         div_trial = {rem_in, div_in[pvts_pkg::SUM_W-1]};
         div_in    = {div_in[pvts_pkg::SUM_W-2:0], 1'b0};
         if (div_trial >= pvts_pkg::DIV_BASE) begin
            rem_in    = pvts_pkg::REM_W'(div_trial - pvts_pkg::DIV_BASE);
            div_in[0] = 1'b1;
         end else begin
            rem_in = div_trial[pvts_pkg::REM_W-1:0];
         end
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pvts_pkg::ST_IDLE;
         step_ff      <= '0;
         pvld_ff      <= 1'b0;
         div_cnt_ff   <= '0;
         has_node_ff  <= 1'b0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            cc_ff[i]    <= '0;
            fc_ff[i]    <= '0;
            first_ff[i] <= '0;
            prev_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pvld_ff      <= (state_ff == pvts_pkg::ST_MUL);
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         // Fold one edge into the sum, sticking at all ones
         if (state_ff == pvts_pkg::ST_ADD) begin
            if (sum_wide[pvts_pkg::SUM_W]) begin
               sum_ff <= '1;
               ovf_ff <= 1'b1;
            end else begin
               sum_ff <= sum_wide[pvts_pkg::SUM_W-1:0];
            end
         end
         // Update stored points on an accepted command
         if (accept) begin
            case (req_command)
               pvts_pkg::CMD_CELL_CENTRE: cc_ff <= req_pt;
               pvts_pkg::CMD_FACE_CENTRE: begin
                  fc_ff       <= req_pt;
                  has_node_ff <= 1'b0;
               end
               pvts_pkg::CMD_FACE_NODE: begin
                  if (!has_node_ff) begin
                     first_ff <= req_pt;
                  end
                  prev_ff     <= req_pt;
                  has_node_ff <= 1'b1;
               end
               pvts_pkg::CMD_FACE_END: has_node_ff <= 1'b0;
               pvts_pkg::CMD_CELL_END: begin
                  has_node_ff <= 1'b0;
                  sum_ff      <= '0;
                  ovf_ff      <= 1'b0;
               end
               default: ;
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      // Load edge operands
      if (start_edge) begin
         a_ff <= fc_d;
         b_ff <= prev_d;
         d_ff <= is_node ? req_d : first_d;
      end
      // Register the product, then fold it into a cross term or the determinant
      prod_ff  <= mul_p;
      pstep_ff <= step_ff;
      if (pvld_ff) begin
         case (pstep_ff)
            4'd0: cross_ff[0] <= prod_ff[CW-1:0];
            4'd1: cross_ff[0] <= cross_ff[0] - prod_ff[CW-1:0];
            4'd2: cross_ff[1] <= prod_ff[CW-1:0];
            4'd3: cross_ff[1] <= cross_ff[1] - prod_ff[CW-1:0];
            4'd4: cross_ff[2] <= prod_ff[CW-1:0];
            4'd5: cross_ff[2] <= cross_ff[2] - prod_ff[CW-1:0];
            4'd6: det_ff <= {prod_ff[PW-1], prod_ff};
            4'd7, 4'd8: det_ff <= det_ff + {prod_ff[PW-1], prod_ff};
            default: ;
         endcase
      end
      if (state_ff == pvts_pkg::ST_ABS) begin
         mag_ff <= {{(pvts_pkg::SUM_W - DETW + 1){1'b0}}, det_abs[DETW-2:0]};
      end
      // Snapshot the sum for division and shift it left by digits
      if (start_div) begin
         div_ff      <= sum_ff;
         rem_ff      <= '0;
         sat_hold_ff <= ovf_ff;
      end else if (state_ff == pvts_pkg::ST_DIV) begin
         div_ff <= div_in;
         rem_ff <= rem_in;
      end
      if (rsp_load) begin
         rsp_vol_ff <= div_ff[pvts_pkg::VOL_W-1:0];
         rsp_sat_ff <= sat_hold_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_volume = rsp_vol_ff;
   assign rsp_saturated   = rsp_sat_ff;

   // Checks
   a_mul_to_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pvts_pkg::ST_MUL) && (step_ff == pvts_pkg::STEP_LAST)
      |=> (state_ff == pvts_pkg::ST_DRAIN))
      else $error("multiply schedule did not end after the last step");

   a_ovf_sticks: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (sum_ff == '1))
      else $error("overflow flag set without a saturated sum");

   a_abs_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pvts_pkg::ST_ABS) |-> !pvld_ff)
      else $error("product still pending when the determinant is taken");

   a_edge_starts: assert property (@(posedge clock) disable iff (reset)
      start_edge |=> (state_ff == pvts_pkg::ST_MUL) && (step_ff == '0))
      else $error("edge did not start the multiply schedule at step zero");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == pvts_pkg::ST_DONE))
      else $error("result raised outside the divide completion");

endmodule

// ===== dv/polyhedron_volume_tet_sum_top_tb.sv =====
// ----------------------------------------------------------------------------
// polyhedron_volume_tet_sum_top_tb: self-checking bench for the cell volume block
// Streams mesh cells as command transfers and tracks the six-fold tetrahedron
// sum of each cell alongside the design. Every volume transfer is compared with
// the oldest pending cell. Covers directed corner cases, a long face of extreme
// edges, a long output stall, and random cells with random gaps on both channels.
// ----------------------------------------------------------------------------
module polyhedron_volume_tet_sum_top_tb;

   localparam int          COORD_W          = 16;
   localparam int          RANDOM_ITEMS     = 1400;
   localparam int          LONG_FACE_NODES  = 128;
   localparam int          SINK_HOLD_CYCLES = 400;
   localparam int          DRAIN_CYCLES     = 40;
   localparam int unsigned CYCLE_LIMIT      = 2000000;
   localparam int          MAX_REPORTS      = 10;

   // Codes the block must ignore
   localparam logic [pvts_pkg::CMD_W-1:0] CMD_RESERVED_FIRST = 3'd5;
   localparam logic [pvts_pkg::CMD_W-1:0] CMD_RESERVED_LAST  = 3'd7;

   typedef logic signed [COORD_W-1:0] coord_type;

   localparam coord_type COORD_MIN = 16'sh8000;
   localparam coord_type COORD_MAX = 16'sh7fff;

   typedef struct {
      longint x;
      longint y;
      longint z;
   } point_type;

   typedef struct {
      logic [pvts_pkg::VOL_W-1:0] volume;
      logic                       saturated;
   } volume_result_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [pvts_pkg::CMD_W-1:0]    req_command;
   coord_type                     req_coord_x;
   coord_type                     req_coord_y;
   coord_type                     req_coord_z;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [pvts_pkg::VOL_W-1:0]    rsp_cell_volume;
   logic                          rsp_saturated;

   // Tracked cell state
   point_type                     cell_centre;
   point_type                     face_centre;
   point_type                     first_node;
   point_type                     prev_node;
   logic                          face_open     = 1'b0;
   logic [pvts_pkg::SUM_W-1:0]    six_sum       = '0;
   logic                          sum_saturated = 1'b0;

   volume_result_type    expected_volumes[$];

   // Stimulus controls and run statistics
   logic                 req_gaps_on   = 1'b1;
   logic                 rsp_stalls_on = 1'b1;
   logic                 sink_hold     = 1'b0;
   int unsigned          cycle_count   = 0;
   int                   mismatch_count = 0;
   int                   transfers_sent = 0;
   int                   effective_items = 0;
   int                   cells_expected = 0;
   int                   saturated_cells = 0;
   int                   volumes_checked = 0;

   polyhedron_volume_tet_sum_top #(
      .COORD_BITS (COORD_W)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_volume (rsp_cell_volume),
      .rsp_saturated   (rsp_saturated)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Stop a hung run
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles, %0d cells pending", cycle_count,
               expected_volumes.size());
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Volume tracking
   // ------------------------------------------------------------------------

   // Add |(fc-cc) . ((p-cc) x (q-cc))| to the six-fold sum, sticking at all ones
   function automatic void accumulate_edge(point_type p, point_type q);
      longint       ax, ay, az, bx, by, bz, dx, dy, dz, det;
      logic [63:0]  mag;
      logic [64:0]  total;
      ax = face_centre.x - cell_centre.x;
      ay = face_centre.y - cell_centre.y;
      az = face_centre.z - cell_centre.z;
      bx = p.x - cell_centre.x;
      by = p.y - cell_centre.y;
      bz = p.z - cell_centre.z;
      dx = q.x - cell_centre.x;
      dy = q.y - cell_centre.y;
      dz = q.z - cell_centre.z;
      det = ax * (by * dz - bz * dy) + ay * (bz * dx - bx * dz) + az * (bx * dy - by * dx);
      mag = (det < 0) ? 64'(-det) : 64'(det);
      total = {1'b0, six_sum} + {1'b0, mag};
      if (total[64]) begin
         six_sum       = '1;
         sum_saturated = 1'b1;
      end else begin
         six_sum = total[63:0];
      end
   endfunction

   // Advance the tracked state by one accepted command
   function automatic void track_command(logic [pvts_pkg::CMD_W-1:0] cmd, coord_type x,
                                         coord_type y, coord_type z);
      point_type                   pt;
      volume_result_type           res;
      logic [pvts_pkg::SUM_W-1:0]  quotient;
      pt.x = longint'(x);
      pt.y = longint'(y);
      pt.z = longint'(z);
      case (cmd)
         pvts_pkg::CMD_CELL_CENTRE: cell_centre = pt;
         pvts_pkg::CMD_FACE_CENTRE: begin
            face_centre = pt;
            face_open   = 1'b0;
         end
         pvts_pkg::CMD_FACE_NODE: begin
            if (!face_open) begin
               first_node = pt;
               face_open  = 1'b1;
            end else begin
               accumulate_edge(prev_node, pt);
            end
            prev_node = pt;
         end
         pvts_pkg::CMD_FACE_END: begin
            if (face_open) accumulate_edge(prev_node, first_node);
            face_open = 1'b0;
         end
         pvts_pkg::CMD_CELL_END: begin
            quotient      = six_sum / 64'd6;
            res.volume    = quotient[pvts_pkg::VOL_W-1:0];
            res.saturated = sum_saturated;
            expected_volumes.push_back(res);
            cells_expected++;
            if (sum_saturated) saturated_cells++;
            six_sum       = '0;
            sum_saturated = 1'b0;
            face_open     = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Command channel
   // ------------------------------------------------------------------------

   // Offer one command, after a random gap when gaps are on, and hold it until the transfer
   task automatic send_item(input logic [pvts_pkg::CMD_W-1:0] cmd, input coord_type x,
                            input coord_type y, input coord_type z);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      do @(posedge clock); while (!req_ready);
      track_command(cmd, x, y, z);
      transfers_sent++;
      if (cmd <= pvts_pkg::CMD_CELL_END) effective_items++;
   endtask

   // Drop valid and wait until every pending cell volume has come back
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_volumes.size() != 0) @(posedge clock);
   endtask

   // Full-range, small, moderate and extreme coordinates
   function automatic coord_type rand_coord();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return coord_type'($urandom);
      if (pick < 7) return coord_type'(int'($urandom_range(0, 4095)) - 2048);
      if (pick < 9) return coord_type'(int'($urandom_range(0, 32767)) - 16384);
      case ($urandom_range(0, 3))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return coord_type'(0);
         default: return coord_type'(-1);
      endcase
   endfunction

   task automatic send_random_point(input logic [pvts_pkg::CMD_W-1:0] cmd);
      send_item(cmd, rand_coord(), rand_coord(), rand_coord());
   endtask

   // One mostly well-formed cell: open faces, empty faces and centre moves mixed in
   task automatic send_random_cell();
      int n_faces;
      int n_nodes;
      send_random_point(pvts_pkg::CMD_CELL_CENTRE);
      n_faces = $urandom_range(1, 4);
      for (int f = 0; f < n_faces; f++) begin
         if ($urandom_range(0, 19) == 0) send_random_point(pvts_pkg::CMD_CELL_CENTRE);
         send_random_point(pvts_pkg::CMD_FACE_CENTRE);
         n_nodes = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 6);
         for (int n = 0; n < n_nodes; n++) send_random_point(pvts_pkg::CMD_FACE_NODE);
         // leave some faces open for the next face or the cell end
         if ($urandom_range(0, 9) != 0) send_random_point(pvts_pkg::CMD_FACE_END);
      end
      send_random_point(pvts_pkg::CMD_CELL_END);
   endtask

   // ------------------------------------------------------------------------
   // Result channel
   // ------------------------------------------------------------------------

   // Draw a stall after each volume transfer; hold off entirely on request
   always @(posedge clock) begin : result_sink
      int pause;
      int sink_wait;
      if (reset) begin
         rsp_ready <= 1'b0;
         sink_wait = 0;
      end else if (sink_hold) begin
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         pause = rsp_stalls_on ? $urandom_range(0, 6) : 0;
         rsp_ready <= (pause == 0);
         sink_wait = (pause == 0) ? 0 : pause - 1;
      end else if (sink_wait > 0) begin
         rsp_ready <= 1'b0;
         sink_wait = sink_wait - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic void flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("Mismatch in %s at cycle %0d: expected 0x%0h, got 0x%0h", what,
                  cycle_count, want, got);
   endfunction

   // Compare each volume transfer with the oldest pending cell
   always @(posedge clock) begin : volume_check
      volume_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_volumes.size() == 0) begin
            flag_mismatch("volume with no cell pending", '0, 64'(rsp_cell_volume));
         end else begin
            want = expected_volumes.pop_front();
            volumes_checked++;
            if (rsp_cell_volume !== want.volume)
               flag_mismatch("cell_volume", 64'(want.volume), 64'(rsp_cell_volume));
            if (rsp_saturated !== want.saturated)
               flag_mismatch("saturated", 64'(want.saturated), 64'(rsp_saturated));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Cell end straight after reset gives zero
   task automatic test_empty_cell();
      send_random_point(pvts_pkg::CMD_CELL_END);
      wait_results_drained();
   endtask

   // Triangle face at the coordinate extremes, largest possible edge terms
   task automatic test_extreme_face();
      send_item(pvts_pkg::CMD_CELL_CENTRE, COORD_MIN, COORD_MIN, COORD_MIN);
      send_item(pvts_pkg::CMD_FACE_CENTRE, COORD_MAX, COORD_MAX, COORD_MIN);
      send_item(pvts_pkg::CMD_FACE_NODE,   COORD_MIN, COORD_MAX, COORD_MAX);
      send_item(pvts_pkg::CMD_FACE_NODE,   COORD_MAX, COORD_MIN, COORD_MAX);
      send_item(pvts_pkg::CMD_FACE_NODE,   COORD_MAX, COORD_MAX, COORD_MAX);
      send_random_point(pvts_pkg::CMD_FACE_END);
      send_random_point(pvts_pkg::CMD_CELL_END);
      wait_results_drained();
   endtask

   // Single-node face, empty face end, reopened face, ignored codes, centre move,
   // cell end with a face still open
   task automatic test_face_corner_cases();
      send_item(pvts_pkg::CMD_CELL_CENTRE, 16'sd256, -16'sd512, 16'sd0);
      send_item(pvts_pkg::CMD_FACE_CENTRE, 16'sd1024, 16'sd300, -16'sd700);
      send_item(pvts_pkg::CMD_FACE_NODE,   -16'sd900, 16'sd1200, 16'sd50);
      send_random_point(pvts_pkg::CMD_FACE_END);
      send_random_point(pvts_pkg::CMD_FACE_END);
      send_item(pvts_pkg::CMD_FACE_CENTRE, -16'sd2000, 16'sd100, 16'sd3000);
      send_item(pvts_pkg::CMD_FACE_NODE,   16'sd700, -16'sd800, 16'sd900);
      send_item(pvts_pkg::CMD_FACE_NODE,   -16'sd1500, 16'sd2500, -16'sd400);
      send_item(pvts_pkg::CMD_FACE_CENTRE, 16'sd5000, -16'sd6000, 16'sd7000);
      send_item(pvts_pkg::CMD_FACE_NODE,   16'sd100, 16'sd200, -16'sd300);
      send_item(pvts_pkg::CMD_FACE_NODE,   -16'sd4000, 16'sd800, 16'sd1600);
      for (int c = CMD_RESERVED_FIRST; c <= CMD_RESERVED_LAST; c++)
         send_random_point(pvts_pkg::CMD_W'(c));
      send_item(pvts_pkg::CMD_CELL_CENTRE, COORD_MAX, COORD_MIN, -16'sd1);
      send_item(pvts_pkg::CMD_FACE_NODE,   16'sd3000, 16'sd3000, 16'sd3000);
      send_random_point(pvts_pkg::CMD_CELL_END);
      wait_results_drained();
   endtask

   // Alternate two extreme nodes on one long face with no gaps so the largest
   // edge terms pile up back to back, then check the next cell starts clean
   task automatic test_long_face();
      req_gaps_on = 1'b0;
      send_item(pvts_pkg::CMD_CELL_CENTRE, COORD_MIN, COORD_MIN, COORD_MIN);
      send_item(pvts_pkg::CMD_FACE_CENTRE, COORD_MAX, COORD_MAX, COORD_MIN);
      for (int n = 0; n < LONG_FACE_NODES; n++) begin
         if (n % 2 == 0)
            send_item(pvts_pkg::CMD_FACE_NODE, COORD_MIN, COORD_MAX, COORD_MAX);
         else
            send_item(pvts_pkg::CMD_FACE_NODE, COORD_MAX, COORD_MIN, COORD_MAX);
      end
      send_random_point(pvts_pkg::CMD_FACE_END);
      send_random_point(pvts_pkg::CMD_CELL_END);
      req_gaps_on = 1'b1;
      send_random_cell();
      wait_results_drained();
   endtask

   // Hold the result side off long enough that cell ends back up into the input
   task automatic test_output_backpressure();
      fork
         begin
            sink_hold <= 1'b1;
            repeat (SINK_HOLD_CYCLES) @(posedge clock);
            sink_hold <= 1'b0;
         end
      join_none
      // short cells fill the output register well inside the hold
      repeat (3) send_random_point(pvts_pkg::CMD_CELL_END);
      repeat (4) send_random_cell();
      wait_results_drained();
   endtask

   // Mostly random cells, some bursts of raw commands, some stretches without gaps
   task automatic test_random_cells();
      int stop_at;
      logic quiet;
      stop_at = effective_items + RANDOM_ITEMS;
      while (effective_items < stop_at) begin
         quiet = ($urandom_range(0, 4) == 0);
         req_gaps_on = !quiet;
         rsp_stalls_on <= !quiet;
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4))
               send_random_point(pvts_pkg::CMD_W'($urandom_range(0, CMD_RESERVED_LAST)));
         end else begin
            send_random_cell();
         end
         if ($urandom_range(0, 15) == 0) wait_results_drained();
      end
      send_random_point(pvts_pkg::CMD_CELL_END);
      req_gaps_on = 1'b1;
      rsp_stalls_on <= 1'b1;
      wait_results_drained();
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_command <= pvts_pkg::CMD_CELL_CENTRE;
      req_coord_x <= '0;
      req_coord_y <= '0;
      req_coord_z <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_cell();
      test_extreme_face();
      test_face_corner_cases();
      test_long_face();
      test_output_backpressure();
      test_random_cells();

      // let any stray volume surface before the verdict
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d command transfers, checked %0d of %0d cell volumes (%0d saturated).",
               transfers_sent, volumes_checked, cells_expected, saturated_cells);
      $display("Included open faces, ignored codes, a long output stall and %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0 && expected_volumes.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
